/* sv/md5sh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_pkg: shared definitions for the seeded MD5 digest engine
// Block geometry, chaining-word constants, step tables and step functions.
// ----------------------------------------------------------------------------
package md5sh_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned WADDR_W     = $clog2(BLOCK_WORDS);
  localparam int unsigned STEP_W      = 6;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [31:0] SEED_MUL_A = 32'd11;
  localparam logic [31:0] SEED_MUL_B = 32'd71;
  localparam logic [31:0] SEED_MUL_C = 32'd37;
  localparam logic [31:0] SEED_MUL_D = 32'd97;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Word slots in the block buffer used by the padding sequence
  localparam logic [WADDR_W-1:0] LAST_ZERO_WORD = WADDR_W'(13);
  localparam logic [WADDR_W-1:0] LEN_LO_WORD    = WADDR_W'(14);
  localparam logic [WADDR_W-1:0] LEN_HI_WORD    = WADDR_W'(15);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(63);

  localparam logic [31:0] STEP_CONST [64] = '{
    32'd3614090360, 32'd3905402710, 32'd606105819,  32'd3250441966,
    32'd4118548399, 32'd1200080426, 32'd2821735955, 32'd4249261313,
    32'd1770035416, 32'd2336552879, 32'd4294925233, 32'd2304563134,
    32'd1804603682, 32'd4254626195, 32'd2792965006, 32'd1236535329,
    32'd4129170786, 32'd3225465664, 32'd643717713,  32'd3921069994,
    32'd3593408605, 32'd38016083,   32'd3634488961, 32'd3889429448,
    32'd568446438,  32'd3275163606, 32'd4107603335, 32'd1163531501,
    32'd2850285829, 32'd4243563512, 32'd1735328473, 32'd2368359562,
    32'd4294588738, 32'd2272392833, 32'd1839030562, 32'd4259657740,
    32'd2763975236, 32'd1272893353, 32'd4139469664, 32'd3200236656,
    32'd681279174,  32'd3936430074, 32'd3572445317, 32'd76029189,
    32'd3654602809, 32'd3873151461, 32'd530742520,  32'd3299628645,
    32'd4096336452, 32'd1126891415, 32'd2878612391, 32'd4237533241,
    32'd1700485571, 32'd2399980690, 32'd4293915773, 32'd2240044497,
    32'd1873313359, 32'd4264355552, 32'd2734768916, 32'd1309151649,
    32'd4149444226, 32'd3174756917, 32'd718787259,  32'd3951481745
  };

  localparam logic [4:0] ROT_AMOUNT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef logic [3:0][WORD_W-1:0] chain_t;

  // Compression unit status towards the sequencer
  typedef struct packed {
    logic   done;
    chain_t word;
  } core_res_t;

  // Message word read by a given step
  function automatic logic [WADDR_W-1:0] msg_index(input logic [STEP_W-1:0] k);
    logic [3:0] k4;
    logic [3:0] idx;
    k4 = k[3:0];
    case (k[5:4])
      2'd0:    idx = k4;
      2'd1:    idx = 4'((k4 << 2) + k4 + 4'd1);
      2'd2:    idx = 4'((k4 << 1) + k4 + 4'd5);
      default: idx = 4'((k4 << 3) - k4);
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (rnd)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

/* sv/md5sh_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_in_if: message byte channel
// Valid/ready channel carrying one message byte and its framing marks.
// ----------------------------------------------------------------------------
interface md5sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output has_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last_byte,
                  output ready);
endinterface

/* sv/md5sh_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_out_if: digest word channel
// Valid/ready channel carrying one chaining word of the finished digest.
// ----------------------------------------------------------------------------
interface md5sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

/* sv/md5sh_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module md5sh_ram #(
  parameter int unsigned WIDTH = md5sh_pkg::WORD_W,
  parameter int unsigned DEPTH = md5sh_pkg::BLOCK_WORDS,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/md5sh_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_core: iterative MD5 compression unit
// Runs the 64 steps of one block, one step a cycle, on a shared step datapath.
// ----------------------------------------------------------------------------
module md5sh_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  md5sh_pkg::chain_t                   chain_i,
  input  logic [md5sh_pkg::WORD_W-1:0]        w_data,
  output logic [md5sh_pkg::WADDR_W-1:0]       rd_addr,
  output md5sh_pkg::core_res_t                res
);

  logic [31:0]                  a_r, b_r, c_r, d_r;
  logic [md5sh_pkg::STEP_W-1:0] step_r;
  logic                         busy_r;
  logic                         done_r;

  logic [31:0]                  f_val;
  logic [31:0]                  sum;
  logic [31:0]                  t_rot;
  logic [md5sh_pkg::STEP_W-1:0] step_inc;

  always_comb begin
    f_val    = md5sh_pkg::round_f(step_r[5:4], b_r, c_r, d_r);
    sum      = a_r + f_val + w_data + md5sh_pkg::STEP_CONST[step_r];
    t_rot    = md5sh_pkg::rotl(sum, md5sh_pkg::ROT_AMOUNT[{step_r[5:4], step_r[1:0]}]);
    step_inc = step_r + 1'b1;
    // Prefetch the word for the next step; word 0 while waiting for start
    rd_addr  = busy_r ? md5sh_pkg::msg_index(step_inc) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        a_r    <= chain_i[0];
        b_r    <= chain_i[1];
        c_r    <= chain_i[2];
        d_r    <= chain_i[3];
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        a_r    <= d_r;
        d_r    <= c_r;
        c_r    <= b_r;
        b_r    <= b_r + t_rot;
        step_r <= step_inc;
        if (step_r == md5sh_pkg::LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done    = done_r;
  assign res.word[0] = a_r;
  assign res.word[1] = b_r;
  assign res.word[2] = c_r;
  assign res.word[3] = d_r;

endmodule

/* sv/md5_seeded_hash_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_seeded_hash_top: seeded MD5 digest engine
// Hashes a byte stream into four chaining words, one 64-step block at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction per message byte. has_byte marks a real byte,
//            last_byte closes the message (after its byte, if any). A
//            transaction with neither mark is taken and ignored.
//   out_ch : four transactions per message, words A..D; last_word on D.
//   cfg    : cfg_wr_en writes cfg_wr_data to the seed; it takes effect when
//            the next message takes its first transaction.
// Sequence:
//   Each byte transaction is taken while in_ch.ready is high; the 64th byte
//   of a block starts a compression (start, 64 steps on the shared step
//   unit, chaining update), during which in_ch.ready is low.
//   After last_byte: a pad word, up to 13 zero-fill words, the two length
//   words and a compression. When the 0x80 lands in the last 8 bytes of the
//   block the length spills into an extra block: close that block with at
//   most one zero-fill word and its own compression, then write 14 zero-fill
//   words, the two length words and run the final compression.
//   The digest then sits in the chaining registers and drains one word per
//   cycle while out_ch.ready is high; a stall just holds the current word.
//   No new message byte is taken until the fourth word has gone.
// Reset: rst_n (synchronous, active low) clears the seed to 0 and returns
//   the sequencer to idle with an empty message; no clearing pass is needed.
// ----------------------------------------------------------------------------
module md5_seeded_hash_top (
  input  logic        clk,
  input  logic        rst_n,
  md5sh_in_if.sink    in_ch,
  md5sh_out_if.source out_ch,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PADW,
    S_ZERO,
    S_LEN0,
    S_LEN1,
    S_COMP,
    S_OUT
  } state_t;

  localparam int unsigned AW = md5sh_pkg::WADDR_W;

  state_t              state_r, state_nxt;
  logic [31:0]         seed_r;
  md5sh_pkg::chain_t   chain_r, chain_nxt;
  logic [63:0]         bit_cnt_r, bit_cnt_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic                started_r, started_nxt;
  logic                pend_last_r, pend_last_nxt;
  logic                in_pad_r, in_pad_nxt;
  logic                tail_r, tail_nxt;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic [1:0]          oi_r, oi_nxt;
  logic                core_start_r, core_start_nxt;

  logic [5:0]          fill;
  logic [1:0]          lane;
  logic [AW-1:0]       wi;
  logic [31:0]         acc_ins;
  logic [31:0]         pad_word;
  logic                in_take;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [31:0]         ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [31:0]         ram_rdata;
  md5sh_pkg::core_res_t core_res;

  md5sh_ram #(
    .WIDTH(md5sh_pkg::WORD_W),
    .DEPTH(md5sh_pkg::BLOCK_WORDS)
  ) u_block_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  md5sh_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (core_start_r),
    .chain_i(chain_r),
    .w_data (ram_rdata),
    .rd_addr(ram_raddr),
    .res    (core_res)
  );

  // Byte position in the current block, and the lane within its word
  assign fill = bit_cnt_r[8:3];
  assign lane = fill[1:0];
  assign wi   = fill[5:2];

  // Merge the incoming byte into the partial word; build the padding word
  // from the bytes already gathered, 0x80 and zeros above it
  always_comb begin
    acc_ins  = acc_r;
    pad_word = '0;
    for (int j = 0; j < 4; j++) begin
      if (lane == 2'(j)) begin
        acc_ins[8*j +: 8]  = in_ch.data_byte;
        pad_word[8*j +: 8] = md5sh_pkg::PAD_BYTE;
      end else if (lane > 2'(j)) begin
        pad_word[8*j +: 8] = acc_r[8*j +: 8];
      end
    end
  end

  assign in_take = in_ch.valid && in_ch.ready && (in_ch.has_byte || in_ch.last_byte);

  always_comb begin
    state_nxt      = state_r;
    chain_nxt      = chain_r;
    bit_cnt_nxt    = bit_cnt_r;
    acc_nxt        = acc_r;
    started_nxt    = started_r;
    pend_last_nxt  = pend_last_r;
    in_pad_nxt     = in_pad_r;
    tail_nxt       = tail_r;
    wp_nxt         = wp_r;
    oi_nxt         = oi_r;
    ram_we         = 1'b0;
    ram_waddr      = wp_r;
    ram_wdata      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          // Load the seeded chaining words on the first transaction of a message
          if (!started_r) begin
            chain_nxt[0] = md5sh_pkg::INIT_A + 32'(seed_r * md5sh_pkg::SEED_MUL_A);
            chain_nxt[1] = md5sh_pkg::INIT_B + 32'(seed_r * md5sh_pkg::SEED_MUL_B);
            chain_nxt[2] = md5sh_pkg::INIT_C + 32'(seed_r * md5sh_pkg::SEED_MUL_C);
            chain_nxt[3] = md5sh_pkg::INIT_D + 32'(seed_r * md5sh_pkg::SEED_MUL_D);
            started_nxt  = 1'b1;
          end
          if (in_ch.has_byte) begin
            acc_nxt     = acc_ins;
            bit_cnt_nxt = bit_cnt_r + 64'd8;
            if (lane == 2'd3) begin
              ram_we    = 1'b1;
              ram_waddr = wi;
              ram_wdata = acc_ins;
            end
          end
          if (in_ch.has_byte && (fill == 6'h3f)) begin
            state_nxt     = S_COMP;
            pend_last_nxt = in_ch.last_byte;
          end else if (in_ch.last_byte) begin
            state_nxt = S_PADW;
          end
        end
      end

      S_PADW: begin
        ram_we     = 1'b1;
        ram_waddr  = wi;
        ram_wdata  = pad_word;
        in_pad_nxt = 1'b1;
        if (wi > md5sh_pkg::LAST_ZERO_WORD) begin
          // No room for the length: finish this block, then a length-only block
          tail_nxt = 1'b0;
          if (wi == md5sh_pkg::LEN_HI_WORD) begin
            state_nxt = S_COMP;
          end else begin
            wp_nxt    = md5sh_pkg::LEN_HI_WORD;
            state_nxt = S_ZERO;
          end
        end else begin
          tail_nxt = 1'b1;
          if (wi == md5sh_pkg::LAST_ZERO_WORD) begin
            state_nxt = S_LEN0;
          end else begin
            wp_nxt    = wi + 1'b1;
            state_nxt = S_ZERO;
          end
        end
      end

      S_ZERO: begin
        ram_we = 1'b1;
        if (tail_r && (wp_r == md5sh_pkg::LAST_ZERO_WORD)) begin
          state_nxt = S_LEN0;
        end else if (!tail_r && (wp_r == md5sh_pkg::LEN_HI_WORD)) begin
          state_nxt = S_COMP;
        end else begin
          wp_nxt = wp_r + 1'b1;
        end
      end

      S_LEN0: begin
        ram_we    = 1'b1;
        ram_waddr = md5sh_pkg::LEN_LO_WORD;
        ram_wdata = bit_cnt_r[31:0];
        state_nxt = S_LEN1;
      end

      S_LEN1: begin
        ram_we    = 1'b1;
        ram_waddr = md5sh_pkg::LEN_HI_WORD;
        ram_wdata = bit_cnt_r[63:32];
        state_nxt = S_COMP;
      end

      S_COMP: begin
        if (core_res.done) begin
          for (int i = 0; i < 4; i++) begin
            chain_nxt[i] = chain_r[i] + core_res.word[i];
          end
          if (!in_pad_r) begin
            if (pend_last_r) begin
              pend_last_nxt = 1'b0;
              state_nxt     = S_PADW;
            end else begin
              state_nxt = S_IDLE;
            end
          end else if (!tail_r) begin
            tail_nxt  = 1'b1;
            wp_nxt    = '0;
            state_nxt = S_ZERO;
          end else begin
            oi_nxt    = '0;
            state_nxt = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (out_ch.ready) begin
          oi_nxt = oi_r + 1'b1;
          if (oi_r == 2'd3) begin
            // Drop the message state and wait for the next one
            bit_cnt_nxt = '0;
            started_nxt = 1'b0;
            in_pad_nxt  = 1'b0;
            tail_nxt    = 1'b0;
            state_nxt   = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Kick the compression unit on entry to the compress state
    core_start_nxt = (state_nxt == S_COMP) && (state_r != S_COMP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      seed_r       <= '0;
      bit_cnt_r    <= '0;
      started_r    <= 1'b0;
      pend_last_r  <= 1'b0;
      in_pad_r     <= 1'b0;
      tail_r       <= 1'b0;
      wp_r         <= '0;
      oi_r         <= '0;
      core_start_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      started_r    <= started_nxt;
      pend_last_r  <= pend_last_nxt;
      in_pad_r     <= in_pad_nxt;
      tail_r       <= tail_nxt;
      wp_r         <= wp_nxt;
      oi_r         <= oi_nxt;
      core_start_r <= core_start_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
    // Payload: chaining words and the partial word need no reset
    chain_r <= chain_nxt;
    acc_r   <= acc_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.digest_word = chain_r[oi_r];
  assign out_ch.word_index  = oi_r;
  assign out_ch.last_word   = (oi_r == 2'd3);

  // Never take a byte while a digest is still being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while digest pending");

  // The compression unit only starts and finishes under the compress state
  a_start_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    core_start_r |-> (state_r == S_COMP))
    else $error("compression started outside compress state");

  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    core_res.done |-> (state_r == S_COMP))
    else $error("compression finished outside compress state");

  // After the final digest word leaves, the block is ready for a new message
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_word) |=> in_ch.ready)
    else $error("not ready after final digest word");

endmodule
